>>> hdl/rpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpid_pkg;

  localparam logic [15:0] RESET_VALUE = 16'd1500;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_SWEEP   = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_kind_e;

  typedef enum logic [2:0] {
    REG_CPPM_MODE   = 3'd0,
    REG_SYNC_GAP    = 3'd1,
    REG_MIN_PULSE   = 3'd2,
    REG_MAX_PULSE   = 3'd3,
    REG_CENTRE      = 3'd4,
    REG_TIMEOUT     = 3'd5
  } reg_idx_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [2:0]  channel;
    logic [15:0] capture_time;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic        cppm_mode;
    logic [15:0] sync_gap;
    logic [15:0] min_pulse;
    logic [15:0] max_pulse;
    logic [15:0] centre_value;
    logic [30:0] timeout_elapsed;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  channel_out;
    logic [15:0] pulse_value;
    logic        value_valid;
    logic        value_updated;
    logic        accepted;
    logic        frame_start;
    logic [7:0]  timed_out_mask;
    logic        receiver_active;
  } result_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SWEEP = 2'b10
  } back_state_e;

endpackage

`default_nettype wire

>>> hdl/rpid_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rpid_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire logic [1:0]     operation_i,
  input  wire logic [2:0]     channel_i,
  input  wire logic [15:0]    capture_time_i,
  input  wire logic [31:0]    now_us_i,
  input  wire logic           deq_i,
  output logic                head_valid_o,
  output rpid_pkg::item_t     head_o
);
  import rpid_pkg::*;

  item_t       slot_q [2];
  logic        wr_q, wr_d, rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        enq;
  item_t       item;

  always_comb begin
    item.kind         = op_kind_e'(operation_i);
    item.channel      = channel_i;
    item.capture_time = capture_time_i;
    item.now_us       = now_us_i;
  end

  assign full         = (cnt_q == 2'd2);
  assign enq          = push && !full;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = enq ? !wr_q : wr_q;
    rd_d  = deq_i ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(enq) - 2'(deq_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_q] <= item;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_deq_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> head_valid_o) else $error("dequeue from empty queue");
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (enq && !deq_i) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("lost transfer");
`endif

endmodule

`default_nettype wire

>>> hdl/rpid_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rpid_back #(
  parameter int CHANNELS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  rpid_pkg::cfg_t       cfg_i,
  input  wire logic            head_valid_i,
  input  rpid_pkg::item_t      head_i,
  output logic                 deq_o,
  output logic                 res_valid_o,
  output rpid_pkg::result_t    res_o,
  input  wire logic            res_pop_i
);
  import rpid_pkg::*;

  localparam int CW = $clog2(CHANNELS);
  localparam int KW = $clog2(CHANNELS + 1);

  logic        phase_q   [CHANNELS];
  logic [15:0] rise_q    [CHANNELS];
  logic [15:0] value_q   [CHANNELS];
  logic        valid_q   [CHANNELS];
  logic        upd_q     [CHANNELS];
  logic [31:0] last_q    [CHANNELS];

  logic [15:0]   latest_q;
  logic [KW-1:0] cur_q, cur_d;
  logic          active_q, active_d;
  back_state_e   st_q, st_d;
  logic [KW-1:0] cnt_q, cnt_d;
  logic [7:0]    mask_q, mask_d;
  logic          out_v_q;
  result_t       out_q;

  logic          can_emit, emit;
  result_t       res;
  logic [4:0]    ch5, cur5, cnt5;
  logic [CW-1:0] idx;
  logic          store, set_rise, clr_phase, expire, upd_latest;
  logic [15:0]   width;
  logic [15:0]   diff, w;
  logic [31:0]   el;
  logic [CW-1:0] sw_idx;

  assign can_emit    = !out_v_q || res_pop_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  assign ch5    = 5'(head_i.channel);
  assign cur5   = 5'(cur_q);
  assign cnt5   = 5'(cnt_q);
  assign sw_idx = cnt_q[CW-1:0];
  assign diff   = head_i.capture_time - latest_q;
  assign el     = head_i.now_us - last_q[sw_idx];

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    mask_d     = mask_q;
    cur_d      = cur_q;
    active_d   = active_q;
    deq_o      = 1'b0;
    emit       = 1'b0;
    store      = 1'b0;
    set_rise   = 1'b0;
    clr_phase  = 1'b0;
    expire     = 1'b0;
    upd_latest = 1'b0;
    width      = diff;
    idx        = ch5[CW-1:0];
    w          = head_i.capture_time - rise_q[ch5[CW-1:0]];
    res        = '0;

    unique case (st_q)
      ST_SWEEP: begin
        if (cnt5 < 5'(CHANNELS)) begin
          expire = valid_q[sw_idx] && !el[31] && (el[30:0] >= cfg_i.timeout_elapsed);
          if (expire && cnt5 < 5'd8) begin
            mask_d[cnt5[2:0]] = 1'b1;
          end
          cnt_d = cnt_q + KW'(1);
        end else if (can_emit) begin
          emit                = 1'b1;
          deq_o               = 1'b1;
          res.timed_out_mask  = mask_q;
          st_d                = ST_RUN;
        end
      end
      default: begin
        if (head_valid_i && can_emit) begin
          unique case (head_i.kind)
            OP_SWEEP: begin
              st_d   = ST_SWEEP;
              cnt_d  = '0;
              mask_d = '0;
            end
            OP_CAPTURE: begin
              emit  = 1'b1;
              deq_o = 1'b1;
              if (cfg_i.cppm_mode) begin
                upd_latest = 1'b1;
                active_d   = 1'b1;
                idx        = cur_q[CW-1:0];
                if (diff > cfg_i.sync_gap) begin
                  cur_d           = '0;
                  res.frame_start = 1'b1;
                  idx             = '0;
                  res.pulse_value   = value_q[0];
                  res.value_valid   = valid_q[0];
                  res.value_updated = upd_q[0];
                end else if (cur5 < 5'(CHANNELS)) begin
                  store = (diff > cfg_i.min_pulse) && (diff < cfg_i.max_pulse);
                  res.channel_out = cur5[2:0];
                  cur_d           = cur_q + KW'(1);
                end
              end else begin
                res.channel_out = head_i.channel;
                if (ch5 < 5'(CHANNELS)) begin
                  if (ch5 == 5'd0) begin
                    active_d = 1'b1;
                  end
                  if (!phase_q[idx]) begin
                    set_rise = 1'b1;
                  end else begin
                    clr_phase = 1'b1;
                    width     = w;
                    store     = (w >= cfg_i.min_pulse) && (w <= cfg_i.max_pulse);
                  end
                end
              end
              if (!res.frame_start && (cfg_i.cppm_mode ? (cur5 < 5'(CHANNELS))
                                                      : (ch5 < 5'(CHANNELS)))) begin
                res.accepted      = store;
                res.pulse_value   = store ? width : value_q[idx];
                res.value_valid   = store | valid_q[idx];
                res.value_updated = store | upd_q[idx];
              end
            end
            OP_READ: begin
              emit  = 1'b1;
              deq_o = 1'b1;
              res.channel_out = head_i.channel;
              if (ch5 < 5'(CHANNELS)) begin
                res.pulse_value   = value_q[idx];
                res.value_valid   = valid_q[idx];
                res.value_updated = upd_q[idx];
              end
            end
            default: begin
              emit  = 1'b1;
              deq_o = 1'b1;
            end
          endcase
        end
      end
    endcase
    res.receiver_active = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_RUN;
      cnt_q    <= '0;
      mask_q   <= '0;
      cur_q    <= '0;
      active_q <= 1'b0;
      latest_q <= '0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i] <= 1'b0;
        rise_q[i]  <= '0;
        value_q[i] <= RESET_VALUE;
        valid_q[i] <= 1'b1;
        upd_q[i]   <= 1'b1;
        last_q[i]  <= '0;
      end
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      mask_q   <= mask_d;
      cur_q    <= cur_d;
      active_q <= active_d;
      if (upd_latest) begin
        latest_q <= head_i.capture_time;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (res_pop_i) begin
        out_v_q <= 1'b0;
      end
      if (set_rise) begin
        rise_q[idx]  <= head_i.capture_time;
        phase_q[idx] <= 1'b1;
      end
      if (clr_phase) begin
        phase_q[idx] <= 1'b0;
      end
      if (store) begin
        value_q[idx] <= width;
        valid_q[idx] <= 1'b1;
        upd_q[idx]   <= 1'b1;
        last_q[idx]  <= head_i.now_us;
      end
      if (expire) begin
        value_q[sw_idx] <= cfg_i.centre_value;
        valid_q[sw_idx] <= 1'b0;
        upd_q[sw_idx]   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SWEEP |-> cnt5 <= 5'(CHANNELS)) else $error("sweep counter overrun");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_emit) else $error("result overwritten");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !res_pop_i) |=> out_v_q) else $error("result dropped");
  a_deq_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o == emit) else $error("item retired without result");
`endif

endmodule

`default_nettype wire

>>> hdl/rc_pulse_input_decoder.sv
// Channel   Direction  Handshake           Payload
// input     in         push / full         operation, channel, capture_time, now_us
// result    out        empty / pop         channel_out .. receiver_active
// config    in         cfg_we_i            cfg_idx_i, cfg_data_i
//
// A capture or read is handled directly from the run state; a timeout sweep
// first enters the sweep state, then checks one channel per cycle through a shared
// compare unit, and then emits the result.
// A two-entry input queue and one result register decouple both sides.
// Reset sets all state at once; no clearing pass.
// A waiting result stalls the back end; the queue keeps taking items until full.
`timescale 1ns / 1ps
`default_nettype none

module rc_pulse_input_decoder #(
  parameter int CHANNELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  operation_i,
  input  wire logic [2:0]  channel_i,
  input  wire logic [15:0] capture_time_i,
  input  wire logic [31:0] now_us_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       channel_out_o,
  output logic [15:0]      pulse_value_o,
  output logic             value_valid_o,
  output logic             value_updated_o,
  output logic             accepted_o,
  output logic             frame_start_o,
  output logic [7:0]       timed_out_mask_o,
  output logic             receiver_active_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i
);
  import rpid_pkg::*;

  cfg_t    cfg_q;
  item_t   head;
  logic    head_valid, deq, res_valid;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cppm_mode       <= 1'b0;
      cfg_q.sync_gap        <= 16'd2700;
      cfg_q.min_pulse       <= 16'd750;
      cfg_q.max_pulse       <= 16'd2250;
      cfg_q.centre_value    <= 16'd1500;
      cfg_q.timeout_elapsed <= 31'd100000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CPPM_MODE: cfg_q.cppm_mode       <= cfg_data_i[0];
        REG_SYNC_GAP:  cfg_q.sync_gap        <= cfg_data_i[15:0];
        REG_MIN_PULSE: cfg_q.min_pulse       <= cfg_data_i[15:0];
        REG_MAX_PULSE: cfg_q.max_pulse       <= cfg_data_i[15:0];
        REG_CENTRE:    cfg_q.centre_value    <= cfg_data_i[15:0];
        REG_TIMEOUT:   cfg_q.timeout_elapsed <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rpid_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .operation_i,
    .channel_i,
    .capture_time_i,
    .now_us_i,
    .deq_i        (deq),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  rpid_back #(.CHANNELS(CHANNELS)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .deq_o        (deq),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_pop_i    (pop && res_valid)
  );

  assign empty             = !res_valid;
  assign channel_out_o     = res.channel_out;
  assign pulse_value_o     = res.pulse_value;
  assign value_valid_o     = res.value_valid;
  assign value_updated_o   = res.value_updated;
  assign accepted_o        = res.accepted;
  assign frame_start_o     = res.frame_start;
  assign timed_out_mask_o  = res.timed_out_mask;
  assign receiver_active_o = res.receiver_active;

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rpid_pkg::*;

  localparam int NCH = 8;
  localparam int LIMIT_CYCLES = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  operation_i = '0;
  logic [2:0]  channel_i = '0;
  logic [15:0] capture_time_i = '0;
  logic [31:0] now_us_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  channel_out_o;
  logic [15:0] pulse_value_o;
  logic        value_valid_o;
  logic        value_updated_o;
  logic        accepted_o;
  logic        frame_start_o;
  logic [7:0]  timed_out_mask_o;
  logic        receiver_active_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [30:0] cfg_data_i = '0;

  rc_pulse_input_decoder dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  cfg_t        cfg;
  logic        phase_q [NCH];
  logic [15:0] rise_q [NCH];
  logic [15:0] val_q [NCH];
  logic        vld_q [NCH];
  logic        upd_q [NCH];
  logic [31:0] stamp_q [NCH];
  logic [15:0] prev_cap, last_cap;
  int unsigned cursor;
  logic        active;

  result_t     pending_results[$];
  int          errors = 0;
  int          n_results = 0;
  int          n_accepted = 0;
  int          n_frames = 0;
  int          n_expired = 0;
  longint      cycles = 0;
  bit          long_hold = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
    errors++;
  endtask

  function automatic void decoder_reset();
    cfg = '{cppm_mode: 1'b0, sync_gap: 16'd2700, min_pulse: 16'd750, max_pulse: 16'd2250,
            centre_value: 16'd1500, timeout_elapsed: 31'd100000};
    for (int i = 0; i < NCH; i++) begin
      phase_q[i] = 1'b0; rise_q[i] = '0; val_q[i] = RESET_VALUE;
      vld_q[i] = 1'b1; upd_q[i] = 1'b1; stamp_q[i] = '0;
    end
    prev_cap = '0; last_cap = '0; cursor = 0; active = 1'b0;
  endfunction

  function automatic void fill_channel(inout result_t r, input int unsigned c);
    r.channel_out = c[2:0];
    if (c < NCH) begin
      r.pulse_value = val_q[c]; r.value_valid = vld_q[c]; r.value_updated = upd_q[c];
    end
  endfunction

  function automatic void store_pulse(int unsigned c, logic [15:0] w, logic [31:0] now);
    val_q[c] = w; vld_q[c] = 1'b1; upd_q[c] = 1'b1; stamp_q[c] = now;
  endfunction

  function automatic result_t decode_item(item_t it);
    result_t     r;
    logic [15:0] w;
    logic [31:0] el;
    r = '0;
    case (it.kind)
      OP_CAPTURE: begin
        if (cfg.cppm_mode) begin
          prev_cap = last_cap; last_cap = it.capture_time; active = 1'b1;
          w = last_cap - prev_cap;
          if (w > cfg.sync_gap) begin
            cursor = 0; r.frame_start = 1'b1; fill_channel(r, 0);
          end else if (cursor < NCH) begin
            if (w > cfg.min_pulse && w < cfg.max_pulse) begin
              store_pulse(cursor, w, it.now_us); r.accepted = 1'b1;
            end
            fill_channel(r, cursor);
            cursor++;
          end
        end else begin
          if (it.channel == 0) active = 1'b1;
          if (!phase_q[it.channel]) begin
            rise_q[it.channel] = it.capture_time; phase_q[it.channel] = 1'b1;
          end else begin
            w = it.capture_time - rise_q[it.channel];
            if (w >= cfg.min_pulse && w <= cfg.max_pulse) begin
              store_pulse(it.channel, w, it.now_us); r.accepted = 1'b1;
            end
            phase_q[it.channel] = 1'b0;
          end
          fill_channel(r, it.channel);
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < NCH; i++) begin
          el = it.now_us - stamp_q[i];
          if (vld_q[i] && !el[31] && el >= {1'b0, cfg.timeout_elapsed}) begin
            val_q[i] = cfg.centre_value; vld_q[i] = 1'b0; upd_q[i] = 1'b1;
            r.timed_out_mask[i] = 1'b1;
          end
        end
      end
      OP_READ: fill_channel(r, it.channel);
      default: ;
    endcase
    r.receiver_active = active;
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [30:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= data;
    case (idx)
      REG_CPPM_MODE: cfg.cppm_mode = data[0];
      REG_SYNC_GAP:  cfg.sync_gap = data[15:0];
      REG_MIN_PULSE: cfg.min_pulse = data[15:0];
      REG_MAX_PULSE: cfg.max_pulse = data[15:0];
      REG_CENTRE:    cfg.centre_value = data[15:0];
      REG_TIMEOUT:   cfg.timeout_elapsed = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * NCH + 4) @(posedge clk_i);
  endtask

  // push one item; hold push high across back-to-back items
  task automatic send_item(item_t it, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    operation_i <= it.kind; channel_i <= it.channel;
    capture_time_i <= it.capture_time; now_us_i <= it.now_us;
    do @(posedge clk_i); while (full);
    pending_results.push_back(decode_item(it));
  endtask

  task automatic end_burst();
    push <= 1'b0;
  endtask

  function automatic item_t mk(op_kind_e k, int unsigned ch, int unsigned cap,
                               logic [31:0] now);
    item_t it;
    it.kind = k; it.channel = ch[2:0]; it.capture_time = cap[15:0]; it.now_us = now;
    return it;
  endfunction

  // result side
  initial begin
    int      hold;
    result_t want;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        pop <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 1)) hold = 0;
      if (hold > 0) begin
        pop <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (want.accepted) n_accepted++;
        if (want.frame_start) n_frames++;
        if (want.timed_out_mask != 0) n_expired++;
        if (channel_out_o !== want.channel_out)
          report_mismatch("channel_out", channel_out_o, want.channel_out);
        if (pulse_value_o !== want.pulse_value)
          report_mismatch("pulse_value", pulse_value_o, want.pulse_value);
        if (value_valid_o !== want.value_valid)
          report_mismatch("value_valid", value_valid_o, want.value_valid);
        if (value_updated_o !== want.value_updated)
          report_mismatch("value_updated", value_updated_o, want.value_updated);
        if (accepted_o !== want.accepted)
          report_mismatch("accepted", accepted_o, want.accepted);
        if (frame_start_o !== want.frame_start)
          report_mismatch("frame_start", frame_start_o, want.frame_start);
        if (timed_out_mask_o !== want.timed_out_mask)
          report_mismatch("timed_out_mask", timed_out_mask_o, want.timed_out_mask);
        if (receiver_active_o !== want.receiver_active)
          report_mismatch("receiver_active", receiver_active_o, want.receiver_active);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles", cycles);
        $display("rc_pulse_input_decoder test failed");
        $finish;
      end
    end
  end

  typedef struct {
    item_t   it;
    bit      fixed;
    result_t want;
  } row_t;

  // stimulus
  initial begin
    row_t        rows[$];
    result_t     r;
    logic [31:0] now;
    logic [15:0] cap;
    int          n;
    decoder_reset();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // parallel mode at reset values
    r = '0; r.pulse_value = RESET_VALUE; r.value_valid = 1'b1; r.value_updated = 1'b1;
    r.channel_out = 3'd7;
    rows.push_back('{mk(OP_READ, 7, 0, 0), 1'b1, r});
    r = '0;
    rows.push_back('{mk(OP_NONE, 7, 16'hFFFF, 32'hFFFF_FFFF), 1'b1, r});
    rows.push_back('{mk(OP_CAPTURE, 0, 16'hFF00, 10), 1'b0, r});
    rows.push_back('{mk(OP_CAPTURE, 0, 16'h01EE, 20), 1'b0, r}); // wrap, 750 exactly
    rows.push_back('{mk(OP_CAPTURE, 1, 100, 30), 1'b0, r});
    rows.push_back('{mk(OP_CAPTURE, 1, 2350, 40), 1'b0, r});     // 2250 exactly
    rows.push_back('{mk(OP_CAPTURE, 2, 0, 50), 1'b0, r});
    rows.push_back('{mk(OP_CAPTURE, 2, 749, 60), 1'b0, r});      // just short
    rows.push_back('{mk(OP_CAPTURE, 3, 0, 70), 1'b0, r});
    rows.push_back('{mk(OP_CAPTURE, 3, 2251, 80), 1'b0, r});     // just long
    rows.push_back('{mk(OP_SWEEP, 0, 0, 32'h8000_0000), 1'b0, r}); // negative age for channels never stored
    rows.push_back('{mk(OP_SWEEP, 0, 0, 100020), 1'b0, r});
    r = '0; r.timed_out_mask = 8'h00;
    r.receiver_active = 1'b1;
    rows.push_back('{mk(OP_SWEEP, 0, 0, 32'h7FFF_FFFF), 1'b1, r});
    rows.push_back('{mk(OP_READ, 4, 0, 0), 1'b0, r});
    foreach (rows[i]) begin
      r = decode_item(rows[i].it);
      if (rows[i].fixed && r !== rows[i].want) begin
        report_mismatch("table row", i, 0);
      end
    end
    decoder_reset();
    foreach (rows[i]) send_item(rows[i].it, 1'b0);
    end_burst();
    drain();

    // CPPM mode, extreme registers
    write_reg(REG_CPPM_MODE, 31'd1);
    write_reg(REG_TIMEOUT, 31'h7FFF_FFFF);
    write_reg(REG_CENTRE, 31'hFFFF);
    cap = 0;
    send_item(mk(OP_CAPTURE, 0, 5000, 1), 1'b0);                 // frame start
    for (int c = 0; c < NCH + 2; c++) begin                       // cursor advances, then holds at the end
      cap = 16'(5000 + (c + 1) * 1000);
      send_item(mk(OP_CAPTURE, 5, cap, 100 + c), 1'b0);
    end
    send_item(mk(OP_CAPTURE, 0, cap + 2700, 200), 1'b0);          // gap not above
    send_item(mk(OP_CAPTURE, 0, cap + 2700 + 2701, 300), 1'b0);  // gap above
    send_item(mk(OP_CAPTURE, 0, cap + 5401 + 750, 300), 1'b0);   // min is exclusive
    send_item(mk(OP_SWEEP, 0, 0, 32'hFFFF_FFFF), 1'b0);
    end_burst();
    drain();
    write_reg(REG_TIMEOUT, 31'd0);
    write_reg(REG_MIN_PULSE, 31'hFFFF);
    write_reg(REG_MAX_PULSE, 31'd0);
    write_reg(REG_SYNC_GAP, 31'hFFFF);
    send_item(mk(OP_SWEEP, 0, 0, 0), 1'b0);
    send_item(mk(OP_CAPTURE, 0, 1000, 0), 1'b0);
    end_burst();
    drain();

    // random phases, pressure in the first one
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_CPPM_MODE, 31'(p[0]));
      write_reg(REG_SYNC_GAP, (p == 7) ? 31'd0 : 31'($urandom_range(2000, 4000)));
      write_reg(REG_MIN_PULSE, (p == 6) ? 31'd0 : 31'($urandom_range(600, 1000)));
      write_reg(REG_MAX_PULSE, (p == 6) ? 31'hFFFF : 31'($urandom_range(1900, 2400)));
      write_reg(REG_CENTRE, 31'($urandom_range(0, 65535)));
      write_reg(REG_TIMEOUT, (p == 5) ? 31'd1 : 31'($urandom_range(1000, 60000)));
      if (p == 0) long_hold = 1'b1;
      now = $urandom;
      cap = 16'($urandom);
      for (n = 0; n < 105; n++) begin
        item_t it;
        int unsigned k, ch;
        now += $urandom_range(0, 20000);
        k = $urandom_range(0, 99);
        ch = $urandom_range(0, 7);
        if (k < 75) begin
          if (cfg.cppm_mode) begin
            if ($urandom_range(0, 9) == 0) cap += 16'($urandom_range(2000, 65535));
            else cap += 16'($urandom_range(500, 2500));
          end else if (phase_q[ch]) begin
            cap = 16'(rise_q[ch] + (($urandom_range(0, 7) == 0) ? $urandom
                                                                 : $urandom_range(500, 2500)));
          end else begin
            cap = 16'($urandom);
          end
          it = mk(OP_CAPTURE, ch, cap, now);
        end else if (k < 85) begin
          it = mk(OP_SWEEP, ch, $urandom, ($urandom_range(0, 9) == 0) ? $urandom : now);
        end else if (k < 97) begin
          it = mk(OP_READ, ch, $urandom, $urandom);
        end else begin
          it = mk(OP_NONE, ch, $urandom, $urandom);
        end
        send_item(it, (n % 40) > 12);
      end
      end_burst();
      drain();
    end

    $display("covered %0d transfers: %0d stored widths, %0d frame starts, %0d sweeps with expiry",
             n_results, n_accepted, n_frames, n_expired);
    $display("both decode modes, register extremes and a long result-side stall");
    if (errors == 0) begin
      $display("rc_pulse_input_decoder test passed");
    end else begin
      $display("rc_pulse_input_decoder test failed");
    end
    $finish;
  end

endmodule
